// ===== rtl/rlap_pkg.sv =====
// shared types, constants and stencil arithmetic for the rgb laplacian filter
`default_nettype none

package rlap_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = NUM_CH * CH_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int NUM_SLOTS  = 4;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(512);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(512);
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(2);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    // result slots in output order for one input pixel
    typedef enum logic [SLOT_W-1:0] {
        SLOT_ABOVE_LEFT = 2'd0,
        SLOT_LAST_LEFT  = 2'd1,
        SLOT_ABOVE_EDGE = 2'd2,
        SLOT_CORNER     = 2'd3
    } slot_t;

    typedef logic [PIX_W-1:0] pixel_t;

    // window indexed [row][col], row 2 and col 2 are the newest
    typedef logic [2:0][2:0][PIX_W-1:0] window_t;

    typedef struct packed {
        pixel_t older;
        pixel_t newer;
    } line_pair_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        line_pair_t       data;
    } line_wr_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_row;
        logic             last_col;
    } pix_pos_t;

    typedef struct packed {
        pixel_t           chans;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } result_t;

    function automatic logic [CH_W-1:0] lap_chan(
        input logic [CH_W-1:0] ce,
        input logic [CH_W-1:0] up,
        input logic [CH_W-1:0] dn,
        input logic [CH_W-1:0] lf,
        input logic [CH_W-1:0] rt
    );
        logic [CH_W+1:0] nsum;
        logic [CH_W+1:0] four_ce;
        logic [CH_W+1:0] mag;
        nsum    = {2'b00, up} + {2'b00, dn} + {2'b00, lf} + {2'b00, rt};
        four_ce = {ce, 2'b00};
        mag     = (nsum >= four_ce) ? (nsum - four_ce) : (four_ce - nsum);
        // times 8 saturates once the magnitude reaches 32
        if (mag[CH_W+1:CH_W-3] != '0)
            return '1;
        else
            return {mag[CH_W-4:0], 3'b000};
    endfunction

    function automatic pixel_t lap_pixel(
        input pixel_t ce,
        input pixel_t up,
        input pixel_t dn,
        input pixel_t lf,
        input pixel_t rt
    );
        pixel_t q;
        q = '0;
        for (int k = 0; k < NUM_CH; k++)
        begin
            q[k*CH_W +: CH_W] = lap_chan(ce[k*CH_W +: CH_W], up[k*CH_W +: CH_W],
                                         dn[k*CH_W +: CH_W], lf[k*CH_W +: CH_W],
                                         rt[k*CH_W +: CH_W]);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rlap_if.sv =====
// handshake interfaces for pixel input, filtered result output and configuration
`default_nettype none

interface rlap_pix_if import rlap_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_ch0;
    logic [CH_W-1:0] in_ch1;
    logic [CH_W-1:0] in_ch2;

    modport source (output valid, output in_ch0, output in_ch1, output in_ch2, input ready);
    modport sink   (input valid, input in_ch0, input in_ch1, input in_ch2, output ready);
endinterface

interface rlap_res_if import rlap_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  out_ch0;
    logic [CH_W-1:0]  out_ch1;
    logic [CH_W-1:0]  out_ch2;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             run_last;
    logic             frame_done;

    modport source (output valid, output out_ch0, output out_ch1, output out_ch2,
                    output out_row, output out_col, output run_last, output frame_done,
                    input ready);
    modport sink   (input valid, input out_ch0, input out_ch1, input out_ch2,
                    input out_row, input out_col, input run_last, input frame_done,
                    output ready);
endinterface

interface rlap_cfg_if import rlap_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rlap_line_store.sv =====
// two-row line store, one entry per column holding the older and newer row
`default_nettype none

module rlap_line_store import rlap_pkg::*; (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output line_pair_t       rd_data,
    input  line_wr_t         wr
);

    line_pair_t mem [MAX_WIDTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/rlap_stencil.sv =====
// 4-neighbour stencil with reflect-101 borders, up to four results per pixel
`default_nettype none

module rlap_stencil import rlap_pkg::*; (
    input  window_t                      win,
    input  pix_pos_t                     pos,
    output result_t [NUM_SLOTS-1:0]      results,
    output logic    [NUM_SLOTS-1:0]      slot_valid
);

    logic             row_one;
    logic             col_one;
    logic             has_left;
    logic             has_above;
    logic [ROW_W-1:0] row_m1;
    logic [COL_W-1:0] col_m1;
    pixel_t           up_a;
    pixel_t           lf_a;
    pixel_t           lf_b;
    pixel_t           up_c;

    always_comb
    begin
        row_one   = (pos.row == ROW_W'(1));
        col_one   = (pos.col == COL_W'(1));
        has_left  = (pos.col != '0);
        has_above = (pos.row != '0);
        row_m1    = pos.row - ROW_W'(1);
        col_m1    = pos.col - COL_W'(1);

        // mirror the missing top / left neighbour onto the one below / right
        up_a = row_one ? win[2][1] : win[0][1];
        lf_a = col_one ? win[1][2] : win[1][0];
        lf_b = col_one ? win[2][2] : win[2][0];
        up_c = row_one ? win[2][2] : win[0][2];

        results[SLOT_ABOVE_LEFT].chans = lap_pixel(win[1][1], up_a, win[2][1], lf_a, win[1][2]);
        results[SLOT_ABOVE_LEFT].row   = row_m1;
        results[SLOT_ABOVE_LEFT].col   = col_m1;

        results[SLOT_LAST_LEFT].chans  = lap_pixel(win[2][1], win[1][1], win[1][1], lf_b,
                                                   win[2][2]);
        results[SLOT_LAST_LEFT].row    = pos.row;
        results[SLOT_LAST_LEFT].col    = col_m1;

        results[SLOT_ABOVE_EDGE].chans = lap_pixel(win[1][2], up_c, win[2][2], win[1][1],
                                                   win[1][1]);
        results[SLOT_ABOVE_EDGE].row   = row_m1;
        results[SLOT_ABOVE_EDGE].col   = pos.col;

        results[SLOT_CORNER].chans     = lap_pixel(win[2][2], win[1][2], win[1][2], win[2][1],
                                                   win[2][1]);
        results[SLOT_CORNER].row       = pos.row;
        results[SLOT_CORNER].col       = pos.col;

        slot_valid[SLOT_ABOVE_LEFT] = has_left && has_above;
        slot_valid[SLOT_LAST_LEFT]  = has_left && pos.last_row;
        slot_valid[SLOT_ABOVE_EDGE] = pos.last_col && has_above;
        slot_valid[SLOT_CORNER]     = pos.last_col && pos.last_row;
    end

endmodule

`default_nettype wire

// ===== rtl/rgb_laplacian_3x3_mirror_core.sv =====
// top level of the streaming rgb 4-neighbour laplacian filter
//
// pixels enter on pix in raster order, three 8-bit channels each; filtered
// pixels leave on res with their row and column, run_last on the final
// result caused by an input and frame_done on the frame's last pixel.
// cfg writes image_width (index 0) or image_height (index 1) and restarts
// the frame; cfg is always ready and must be written only while the block is
// idle, which the block itself does not enforce. an input transfer is
// registered together with its line store read; once the buffer is free the
// window shifts and its results fill a four-slot buffer that drives res.
// output trails input by one row and one column; inputs in the last column
// or last row also flush the remaining pixels, up to four results.
// throughput is one pixel per cycle while res is ready and each pixel causes
// at most one result; an input causing more results holds the input while
// the single result port drains the buffer one slot per cycle while res is ready.
// when res stalls the buffer holds and pix backs up after one more pixel.
// reset restores 512 x 512, clears the position and empties the pipeline;
// line store contents are not cleared and need no clearing pass.
`default_nettype none

module rgb_laplacian_3x3_mirror_core import rlap_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    rlap_cfg_if.sink     cfg,
    rlap_pix_if.sink     pix,
    rlap_res_if.source   res
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    pixel_t              s1_pix_reg;
    pix_pos_t            s1_pos_reg;

    window_t             win_reg;
    window_t             win_next;

    result_t [NUM_SLOTS-1:0] buf_reg;
    logic    [NUM_SLOTS-1:0] mask_reg;
    logic    [NUM_SLOTS-1:0] mask_next;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [COL_W-1:0]    c_eff;
    logic                last_row_in;
    logic                last_col_in;
    logic                cfg_hit;
    logic                pix_fire;
    logic                res_fire;
    logic                buf_free;
    logic                s1_adv;

    line_pair_t          rd_data;
    line_wr_t            line_wr;

    result_t [NUM_SLOTS-1:0] stencil_results;
    logic    [NUM_SLOTS-1:0] stencil_valid;

    logic    [NUM_SLOTS-1:0] low_bit;
    slot_t                   sel;
    result_t                 sel_res;

    // effective frame size and clamped column
    always_comb
    begin
        if (width_reg < WIDTH_MIN)
            w_eff = WIDTH_MIN;
        else if (width_reg > WIDTH_MAX)
            w_eff = WIDTH_MAX;
        else
            w_eff = width_reg;

        h_eff = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;

        if ({1'b0, col_reg} >= w_eff)
            c_eff = COL_W'(w_eff - WIDTH_W'(1));
        else
            c_eff = col_reg;

        last_row_in = ({1'b0, row_reg} + (ROW_W+1)'(1)) >= {1'b0, h_eff};
        last_col_in = ({1'b0, c_eff} + WIDTH_W'(1)) >= w_eff;
    end

    assign cfg.ready = 1'b1;
    assign cfg_hit   = cfg.valid && ((cfg.index == REG_IMAGE_WIDTH) ||
                                     (cfg.index == REG_IMAGE_HEIGHT));

    assign res_fire  = res.valid && res.ready;
    assign buf_free  = (mask_reg == '0) ||
                       (res_fire && ((mask_reg & (mask_reg - NUM_SLOTS'(1))) == '0));
    assign s1_adv    = s1_valid_reg && buf_free;
    assign pix.ready = !s1_valid_reg || s1_adv;
    assign pix_fire  = pix.valid && pix.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg.data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg.data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // raster position of the next input pixel
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        priority if (cfg_hit)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (pix_fire)
        begin
            if (last_col_in)
            begin
                col_next = '0;
                row_next = last_row_in ? '0 : (row_reg + ROW_W'(1));
            end
            else
            begin
                col_next = c_eff + COL_W'(1);
            end
        end
        else
        begin
            row_next = row_reg;
            col_next = col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // input register stage, line store read is issued at the same time
    always_comb
    begin
        if (pix_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_pix_reg          <= {pix.in_ch2, pix.in_ch1, pix.in_ch0};
            s1_pos_reg.row      <= row_reg;
            s1_pos_reg.col      <= c_eff;
            s1_pos_reg.last_row <= last_row_in;
            s1_pos_reg.last_col <= last_col_in;
        end
    end

    // older row takes the newer one, newer row takes this pixel
    assign line_wr.en         = s1_adv;
    assign line_wr.addr       = s1_pos_reg.col;
    assign line_wr.data.older = rd_data.newer;
    assign line_wr.data.newer = s1_pix_reg;

    rlap_line_store u_line_store (
        .clk     (clk),
        .rd_en   (pix_fire),
        .rd_addr (c_eff),
        .rd_data (rd_data),
        .wr      (line_wr)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = rd_data.older;
        win_next[1][2] = rd_data.newer;
        win_next[2][2] = s1_pix_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            win_reg <= win_next;
        end
    end

    rlap_stencil u_stencil (
        .win        (win_next),
        .pos        (s1_pos_reg),
        .results    (stencil_results),
        .slot_valid (stencil_valid)
    );

    // result buffer, drained lowest slot first
    always_comb
    begin
        low_bit = mask_reg & (~mask_reg + NUM_SLOTS'(1));
        priority if (mask_reg[SLOT_ABOVE_LEFT])
            sel = SLOT_ABOVE_LEFT;
        else if (mask_reg[SLOT_LAST_LEFT])
            sel = SLOT_LAST_LEFT;
        else if (mask_reg[SLOT_ABOVE_EDGE])
            sel = SLOT_ABOVE_EDGE;
        else
            sel = SLOT_CORNER;
        sel_res = buf_reg[sel];

        if (s1_adv)
            mask_next = stencil_valid;
        else if (res_fire)
            mask_next = mask_reg & ~low_bit;
        else
            mask_next = mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            buf_reg <= stencil_results;
        end
    end

    assign res.valid      = (mask_reg != '0);
    assign res.out_ch0    = sel_res.chans[0*CH_W +: CH_W];
    assign res.out_ch1    = sel_res.chans[1*CH_W +: CH_W];
    assign res.out_ch2    = sel_res.chans[2*CH_W +: CH_W];
    assign res.out_row    = sel_res.row;
    assign res.out_col    = sel_res.col;
    assign res.run_last   = ((mask_reg & ~low_bit) == '0);
    assign res.frame_done = (sel == SLOT_CORNER);

endmodule

`default_nettype wire

// ===== bench/tb_rgb_laplacian_3x3_mirror_core.sv =====
// self-checking testbench of the rgb 4-neighbour laplacian core: directed and random frames against a stencil ledger
module tb_rgb_laplacian_3x3_mirror_core import rlap_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 220;
    localparam int WIDE_ITEMS     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {PIX_NOISE, PIX_SMOOTH, PIX_EXTREME} pix_mode_e;
    typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_BLOCK} rx_mode_e;

    typedef struct packed {
        logic [CH_W-1:0]  ch0;
        logic [CH_W-1:0]  ch1;
        logic [CH_W-1:0]  ch2;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             run_last;
        logic             frame_done;
    } filt_result_t;

    class edge_map_ledger;
        pixel_t             older_row [MAX_WIDTH];
        pixel_t             newer_row [MAX_WIDTH];
        pixel_t             win [3][3];
        logic [WIDTH_W-1:0]  width_reg;
        logic [HEIGHT_W-1:0] height_reg;
        int unsigned        row_pos;
        int unsigned        col_pos;
        filt_result_t       queued_results [$];
        int                 errors;
        int                 pixels_in;
        int                 results_seen;
        int                 frames_seen;

        function new();
            width_reg    = WIDTH_RESET;
            height_reg   = HEIGHT_RESET;
            row_pos      = 0;
            col_pos      = 0;
            errors       = 0;
            pixels_in    = 0;
            results_seen = 0;
            frames_seen  = 0;
            foreach (older_row[i])
            begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            foreach (win[i, j])
                win[i][j] = '0;
        endfunction

        function int frame_width();
            if (width_reg < 2)
                return 2;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int frame_height();
            if (height_reg < 2)
                return 2;
            return int'(height_reg);
        endfunction

        function int pending();
            return queued_results.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = value[WIDTH_W-1:0];
            else if (idx == REG_IMAGE_HEIGHT)
                height_reg = value[HEIGHT_W-1:0];
            else
                return;
            // any size write restarts the frame
            row_pos = 0;
            col_pos = 0;
        endfunction

        function pixel_t stencil(pixel_t ce, pixel_t up, pixel_t dn, pixel_t lf, pixel_t rt);
            pixel_t q;
            int     s;
            q = '0;
            for (int k = 0; k < NUM_CH; k++)
            begin
                s = int'(up[k*CH_W +: CH_W]) + int'(dn[k*CH_W +: CH_W]) +
                    int'(lf[k*CH_W +: CH_W]) + int'(rt[k*CH_W +: CH_W]) -
                    4 * int'(ce[k*CH_W +: CH_W]);
                if (s < 0)
                    s = -s;
                s = s * 8;
                q[k*CH_W +: CH_W] = (s > 255) ? 8'hFF : s[CH_W-1:0];
            end
            return q;
        endfunction

        function void add_result(pixel_t ce, pixel_t up, pixel_t dn, pixel_t lf, pixel_t rt,
                                 int unsigned row, int unsigned col, bit done);
            filt_result_t e;
            pixel_t       q;
            q            = stencil(ce, up, dn, lf, rt);
            e.ch0        = q[7:0];
            e.ch1        = q[15:8];
            e.ch2        = q[23:16];
            e.row        = row[ROW_W-1:0];
            e.col        = col[COL_W-1:0];
            e.run_last   = 1'b0;
            e.frame_done = done;
            queued_results.push_back(e);
        endfunction

        function void note_pixel(pixel_t px);
            int unsigned  w;
            int unsigned  h;
            int unsigned  r;
            int unsigned  c;
            int           first;
            bit           last_row;
            bit           last_col;
            filt_result_t tail;
            w = frame_width();
            h = frame_height();
            r = row_pos;
            c = col_pos;
            if (c >= w)
                c = w - 1;
            first = queued_results.size();
            for (int i = 0; i < 3; i++)
            begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2]    = older_row[c];
            win[1][2]    = newer_row[c];
            win[2][2]    = px;
            older_row[c] = newer_row[c];
            newer_row[c] = px;
            last_row = (r + 1 >= h);
            last_col = (c + 1 >= w);
            // row 0 and column 0 mirror onto their inner neighbour
            if (c >= 1)
            begin
                if (r >= 1)
                    add_result(win[1][1], (r == 1) ? win[2][1] : win[0][1], win[2][1],
                               (c == 1) ? win[1][2] : win[1][0], win[1][2], r - 1, c - 1, 1'b0);
                if (last_row)
                    add_result(win[2][1], win[1][1], win[1][1],
                               (c == 1) ? win[2][2] : win[2][0], win[2][2], r, c - 1, 1'b0);
            end
            if (last_col)
            begin
                if (r >= 1)
                    add_result(win[1][2], (r == 1) ? win[2][2] : win[0][2], win[2][2],
                               win[1][1], win[1][1], r - 1, c, 1'b0);
                if (last_row)
                    add_result(win[2][2], win[1][2], win[1][2], win[2][1], win[2][1], r, c, 1'b1);
            end
            if (queued_results.size() > first)
            begin
                tail = queued_results.pop_back();
                tail.run_last = 1'b1;
                queued_results.push_back(tail);
            end
            if (last_col)
            begin
                col_pos = 0;
                row_pos = last_row ? 0 : ((r + 1) & 12'hFFF);
            end
            else
            begin
                col_pos = c + 1;
                row_pos = r;
            end
            pixels_in++;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got,
                                    int unsigned row, int unsigned col);
            if (want != got)
            begin
                errors++;
                $display("%0t ns: %s mismatch at row %0d col %0d: expected %0d, actual %0d",
                         $time, name, row, col, want, got);
            end
        endfunction

        function void check_result(filt_result_t got);
            filt_result_t want;
            results_seen++;
            if (queued_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: result with nothing pending: expected none, actual row %0d col %0d",
                         $time, got.row, got.col);
                return;
            end
            want = queued_results.pop_front();
            compare_field("out_ch0", want.ch0, got.ch0, want.row, want.col);
            compare_field("out_ch1", want.ch1, got.ch1, want.row, want.col);
            compare_field("out_ch2", want.ch2, got.ch2, want.row, want.col);
            compare_field("out_row", want.row, got.row, want.row, want.col);
            compare_field("out_col", want.col, got.col, want.row, want.col);
            compare_field("run_last", want.run_last, got.run_last, want.row, want.col);
            compare_field("frame_done", want.frame_done, got.frame_done, want.row, want.col);
            if (want.frame_done)
                frames_seen++;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rlap_cfg_if cfg ();
    rlap_pix_if pix ();
    rlap_res_if res ();

    rgb_laplacian_3x3_mirror_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .pix   (pix),
        .res   (res)
    );

    edge_map_ledger ledger;
    int             burst_left = 0;
    int             cfg_writes = 0;
    int             quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stall pattern, independent of the sender
    initial
    begin
        rx_mode_e mode;
        int       span;
        int       hold;
        hold = 0;
        res.ready <= 1'b0;
        forever
        begin
            mode = rx_mode_e'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    RX_FREE: res.ready <= 1'b1;
                    RX_COIN: res.ready <= 1'($urandom_range(0, 1));
                    RX_SLOW: res.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        if (hold > 0)
                        begin
                            res.ready <= 1'b0;
                            hold--;
                        end
                        else
                        begin
                            res.ready <= 1'b1;
                            if ($urandom_range(0, 3) == 0)
                                hold = $urandom_range(1, 12);
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            ledger.check_result({res.out_ch0, res.out_ch1, res.out_ch2, res.out_row,
                                 res.out_col, res.run_last, res.frame_done});
    end

    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     quiet_cycles, ledger.pending());
            $display("rgb_laplacian_3x3_mirror_core regression: fail");
            $finish;
        end
    end

    task automatic send_pixel(pixel_t px);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                pix.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        pix.valid  <= 1'b1;
        pix.in_ch0 <= px[7:0];
        pix.in_ch1 <= px[15:8];
        pix.in_ch2 <= px[23:16];
        do @(posedge clk); while (!pix.ready);
        ledger.note_pixel(px);
        burst_left--;
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        do @(posedge clk); while (ledger.pending() != 0);
    endtask

    // pixels that cause no result may still be in flight after the last one
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        ledger.write_reg(idx, value);
        cfg_writes++;
    endtask

    task automatic send_run(int count, pix_mode_e mode);
        pixel_t base;
        pixel_t px;
        base = pixel_t'($urandom);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 63) == 0)
                drain();
            px = pixel_t'($urandom);
            case (mode)
                PIX_SMOOTH:
                    for (int k = 0; k < NUM_CH; k++)
                        px[k*CH_W +: CH_W] = (base[k*CH_W +: CH_W] & 8'h7F) +
                                             8'($urandom_range(0, 9));
                PIX_EXTREME:
                    for (int k = 0; k < NUM_CH; k++)
                        px[k*CH_W +: CH_W] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                default: ;
            endcase
            send_pixel(px);
        end
    endtask

    initial
    begin
        int        rand_goal;
        int        pick;
        int        frames;
        int        size;
        int        total;
        pix_mode_e mode;

        ledger = new();
        rst_n      <= 1'b0;
        pix.valid  <= 1'b0;
        pix.in_ch0 <= '0;
        pix.in_ch1 <= '0;
        pix.in_ch2 <= '0;
        cfg.valid  <= 1'b0;
        cfg.index  <= REG_IMAGE_WIDTH;
        cfg.data   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // start of a 512 x 512 frame at reset size, abandoned by the size writes
        send_pixel(24'h123456);
        send_pixel(24'hFEDCBA);
        settle();

        // sizes below the minimum act as 2 x 2: all four results come from the last pixel
        write_reg(REG_IMAGE_WIDTH, 12'd1);
        write_reg(REG_IMAGE_HEIGHT, 12'd0);
        cfg.valid <= 1'b0;
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hFF00FF);
        send_pixel(24'h00FF00);
        settle();

        // unused indexes change nothing, the 2 x 2 size stays
        write_reg(CFG_SPARE_LO, 12'($urandom));
        write_reg(CFG_SPARE_HI, 12'($urandom));
        cfg.valid <= 1'b0;
        send_pixel(24'h050A0F);
        send_pixel(24'h060B0C);
        send_pixel(24'h0A0A0A);
        send_pixel(24'h02FF01);
        settle();

        // 3 x 3 has one interior pixel with true neighbours on all sides
        write_reg(REG_IMAGE_WIDTH, 12'd3);
        write_reg(REG_IMAGE_HEIGHT, 12'd3);
        cfg.valid <= 1'b0;
        for (int i = 0; i < 9; i++)
            send_pixel({8'(128 + i), (i % 2 != 0) ? 8'hFF : 8'h00, 8'(i * 4)});
        settle();

        // tallest frame, cut short
        write_reg(REG_IMAGE_WIDTH, 12'd2);
        write_reg(REG_IMAGE_HEIGHT, 12'hFFF);
        cfg.valid <= 1'b0;
        send_run(64, PIX_NOISE);
        settle();

        // widest frame, an oversized width clamps to the line store depth; cut short
        write_reg(REG_IMAGE_WIDTH, 12'hFFF);
        write_reg(REG_IMAGE_HEIGHT, 12'd2);
        cfg.valid <= 1'b0;
        send_run(WIDE_ITEMS, PIX_SMOOTH);

        rand_goal = ledger.pixels_in + RANDOM_ITEMS;
        while (ledger.pixels_in < rand_goal)
        begin
            settle();
            pick = $urandom_range(0, 3);
            if (pick == 3 && $urandom_range(0, 1) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          12'($urandom));
            if (pick != 1)
                write_reg(REG_IMAGE_WIDTH, {1'($urandom), 11'($urandom_range(0, 9))});
            if (pick != 2)
                write_reg(REG_IMAGE_HEIGHT, 12'($urandom_range(0, 6)));
            cfg.valid <= 1'b0;
            mode   = pix_mode_e'($urandom_range(0, 2));
            frames = $urandom_range(1, 3);
            size   = ledger.frame_width() * ledger.frame_height();
            total  = frames * size;
            // broken frame: the next size write restarts it mid-way
            if ($urandom_range(0, 4) == 0)
                total = total - $urandom_range(1, size - 1);
            send_run(total, mode);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d pixels over %0d register writes, %0d results checked",
                 ledger.pixels_in, cfg_writes, ledger.results_seen);
        $display("frames completed %0d, sizes from 2 x 2 up to 1024 wide and 4095 tall",
                 ledger.frames_seen);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("rgb_laplacian_3x3_mirror_core regression: pass");
        else
            $display("rgb_laplacian_3x3_mirror_core regression: fail");
        $finish;
    end

endmodule
